FILE: hdl/gaussian_line_blur_defines.svh
// assertion macros shared by the gaussian line blur modules
`ifndef GAUSSIAN_LINE_BLUR_DEFINES_SVH
`define GAUSSIAN_LINE_BLUR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GLB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define GLB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/glb_pkg.sv
// shared types, register codes and reset values for the gaussian line blur
package glb_pkg;

  localparam int WEIGHT_W    = 16;
  localparam int FRAC_BITS   = 16;
  localparam int RADIUS_W    = 3;
  localparam int NUM_WEIGHTS = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef weight_t weight_set_t [NUM_WEIGHTS];

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_4 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_5 = 3'd6;

  // register values after reset
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 3'd4;
  localparam weight_set_t WEIGHT_RST = '{16'd26145, 16'd15858, 16'd3538,
                                         16'd290, 16'd9, 16'd0};

  // control bits that travel with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  // accumulator width: signed pair sum times unsigned weight, summed over all taps
  function automatic int glb_acc_w(input int sample_bits, input int max_radius);
    return sample_bits + 1 + WEIGHT_W + 1 + $clog2(max_radius);
  endfunction

endpackage

FILE: hdl/glb_mac_cell.sv
// one tap cell of the filter chain: multiply its operand by its weight and add
`include "gaussian_line_blur_defines.svh"

module glb_mac_cell
  import glb_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_RADIUS  = 6,
  parameter int TAP         = 0
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  stage_ctl_t                                  ctl_in,
  input  logic signed [glb_acc_w(SAMPLE_BITS, MAX_RADIUS)-1:0] acc_in,
  input  logic [MAX_RADIUS*(SAMPLE_BITS+1)-1:0]       ops_in,
  input  weight_t                                     weight,
  input  logic                                        ready_in,
  output logic                                        ready_out,
  output stage_ctl_t                                  ctl_out,
  output logic signed [glb_acc_w(SAMPLE_BITS, MAX_RADIUS)-1:0] acc_out,
  output logic [MAX_RADIUS*(SAMPLE_BITS+1)-1:0]       ops_out
);

  localparam int OP_W   = SAMPLE_BITS + 1;
  localparam int ACC_W  = glb_acc_w(SAMPLE_BITS, MAX_RADIUS);
  localparam int PROD_W = OP_W + WEIGHT_W + 1;

  logic signed [OP_W-1:0]       op;
  logic signed [WEIGHT_W:0]     w_s;
  logic signed [PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]      sum;

  logic                         valid_r;
  logic                         last_r;
  logic signed [ACC_W-1:0]      acc_r;
  logic [MAX_RADIUS*OP_W-1:0]   ops_r;

  // this cell's product and running sum
  assign op   = ops_in[TAP*OP_W +: OP_W];
  assign w_s  = {1'b0, weight};
  assign prod = w_s * op;
  assign sum  = acc_in + ACC_W'(prod);

  // stage moves when empty or when the next cell takes its item
  assign ready_out = !valid_r || ready_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_out) begin
      valid_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && ctl_in.valid) begin
      last_r <= ctl_in.last;
      acc_r  <= sum;
      ops_r  <= ops_in;
    end
  end

  assign ctl_out.valid = valid_r;
  assign ctl_out.last  = last_r;
  assign acc_out       = acc_r;
  assign ops_out       = ops_r;

  // a stalled cell keeps its item and its partial sum
  `GLB_ASSERT_NXT(a_cell_hold, valid_r && !ready_in, valid_r && $stable(acc_r),
                  "mac cell lost or changed a stalled partial sum")

endmodule

FILE: hdl/glb_window.sv
// sample window, output scheduling and tap operand selection
`include "gaussian_line_blur_defines.svh"

module glb_window
  import glb_pkg::*;
#(
  parameter int MAX_RADIUS  = 6,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  input  logic                                  line_end,
  input  logic [RADIUS_W-1:0]                   radius,
  input  logic                                  sel_ready,
  output stage_ctl_t                            sel_ctl,
  output logic [MAX_RADIUS*(SAMPLE_BITS+1)-1:0] sel_ops
);

  localparam int OP_W      = SAMPLE_BITS + 1;
  localparam int WIN_DEPTH = 2 * MAX_RADIUS - 1;
  localparam int IDX_W     = $clog2(WIN_DEPTH);
  localparam logic [RADIUS_W-1:0] R_MAX = RADIUS_W'(MAX_RADIUS);
  localparam logic [RADIUS_W-1:0] R_ONE = RADIUS_W'(1);

  logic signed [SAMPLE_BITS-1:0] win_r [WIN_DEPTH];
  logic [RADIUS_W-1:0]           pend_r;
  logic                          end_r;
  logic                          start_r;
  logic                          sel_valid_r;
  logic                          sel_last_r;
  logic [MAX_RADIUS*OP_W-1:0]    sel_ops_r;

  logic [RADIUS_W-1:0]           r_eff;
  logic [RADIUS_W-1:0]           keep;
  logic [RADIUS_W-1:0]           need;
  logic [RADIUS_W-1:0]           pend_base;
  logic                          sel_up_ready;
  logic                          issue_fire;
  logic                          issue_last;
  logic                          accept;
  logic [IDX_W-1:0]              a_pos;
  logic [MAX_RADIUS*OP_W-1:0]    ops_nxt;

  // radius in use: zero acts as one, large values stop at MAX_RADIUS
  always_comb begin
    priority if (radius == '0) begin
      r_eff = R_ONE;
    end else if (radius > R_MAX) begin
      r_eff = R_MAX;
    end else begin
      r_eff = radius;
    end
  end

  // positions to emit from the current window before the next item may enter
  assign keep = r_eff - R_ONE;
  assign need = end_r ? pend_r : ((pend_r > keep) ? (pend_r - keep) : '0);

  assign sel_up_ready = !sel_valid_r || sel_ready;
  assign issue_fire   = (need != '0) && sel_up_ready;
  assign issue_last   = end_r && (pend_r == R_ONE);
  assign in_tready    = (need == '0) || ((need == R_ONE) && issue_fire);
  assign accept       = in_tvalid && in_tready;
  assign pend_base    = pend_r - (issue_fire ? R_ONE : '0);

  // oldest pending position, counted back from the newest sample
  assign a_pos = IDX_W'(pend_r - R_ONE);

  // centre and mirrored pair sums; older side is edge-filled in the window
  always_comb begin
    logic [IDX_W-1:0] li;
    logic [IDX_W-1:0] ri;
    ops_nxt = '0;
    ops_nxt[0 +: OP_W] = OP_W'(win_r[a_pos]);
    for (int d = 1; d < MAX_RADIUS; d++) begin
      li = a_pos + IDX_W'(d);
      ri = (a_pos >= IDX_W'(d)) ? (a_pos - IDX_W'(d)) : '0;
      if (RADIUS_W'(d) < r_eff) begin
        ops_nxt[d*OP_W +: OP_W] = OP_W'(win_r[li]) + OP_W'(win_r[ri]);
      end
    end
  end

  // scheduling state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      end_r       <= 1'b0;
      start_r     <= 1'b1;
      sel_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pend_r  <= pend_base + R_ONE;
        end_r   <= line_end;
        start_r <= line_end;
      end else begin
        pend_r  <= pend_base;
      end
      if (sel_up_ready) begin
        sel_valid_r <= issue_fire;
      end
    end
  end

  // window shift; the first sample of a line fills every cell
  always_ff @(posedge clk) begin
    if (accept) begin
      if (start_r) begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
          win_r[i] <= sample;
        end
      end else begin
        win_r[0] <= sample;
        for (int i = 1; i < WIN_DEPTH; i++) begin
          win_r[i] <= win_r[i-1];
        end
      end
    end
  end

  // operand register feeding the first cell
  always_ff @(posedge clk) begin
    if (issue_fire) begin
      sel_ops_r  <= ops_nxt;
      sel_last_r <= issue_last;
    end
  end

  assign sel_ctl.valid = sel_valid_r;
  assign sel_ctl.last  = sel_last_r;
  assign sel_ops       = sel_ops_r;

  // the final position of a line empties the schedule
  `GLB_ASSERT_NXT(a_last_empties, issue_fire && issue_last && !accept, pend_r == '0,
                  "positions left pending after the last of a line")
  // every accepted item leaves a position to emit
  `GLB_ASSERT_NXT(a_accept_pends, accept, pend_r != '0,
                  "accepted item left no pending position")
  // a line end arms the flush and the edge fill of the next line
  `GLB_ASSERT_NXT(a_end_arms, accept && line_end, start_r && end_r,
                  "line end did not arm flush and line restart")

endmodule

FILE: hdl/gaussian_line_blur.sv
// Path: once the sample that completes its right neighbors is accepted, a result passes
// through the operand register, the tap cells and the output register to out_tvalid.
// Throughput: one item per cycle along a line unless out_tready stalls the pipeline; an
// item that closes a line holds in_tready low while the window flushes one result per cycle.
// Reset: synchronous on rst_n low; empties the pipeline and the schedule and loads
// the default radius and weights.
module gaussian_line_blur
  import glb_pkg::*;
#(
  parameter int MAX_RADIUS  = 6,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] in_tdata,   // sample
  input  logic                                   in_tlast,   // line_end
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] out_tdata,  // blurred
  output logic                                   out_tlast,  // last_of_line
  input  logic                                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]                   cfg_index,
  input  logic [CFG_DATA_W-1:0]                  cfg_wdata
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OP_W    = SAMPLE_BITS + 1;
  localparam int ACC_W   = glb_acc_w(SAMPLE_BITS, MAX_RADIUS);
  localparam int SH_W    = ACC_W - FRAC_BITS;
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  logic [RADIUS_W-1:0]          radius_r;
  weight_t                      weight_r [NUM_WEIGHTS];

  stage_ctl_t                   cell_ctl   [MAX_RADIUS+1];
  logic signed [ACC_W-1:0]      cell_acc   [MAX_RADIUS+1];
  logic [MAX_RADIUS*OP_W-1:0]   cell_ops   [MAX_RADIUS];
  logic                         cell_ready [MAX_RADIUS+1];

  logic signed [SH_W-1:0]       shifted;
  logic [SAMPLE_BITS-1:0]       blurred;
  logic                         out_valid_r;
  logic                         out_last_r;
  logic [SAMPLE_BITS-1:0]       out_blurred_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      weight_r <= WEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RADIUS:   radius_r    <= cfg_wdata[RADIUS_W-1:0];
        REG_WEIGHT_0: weight_r[0] <= cfg_wdata;
        REG_WEIGHT_1: weight_r[1] <= cfg_wdata;
        REG_WEIGHT_2: weight_r[2] <= cfg_wdata;
        REG_WEIGHT_3: weight_r[3] <= cfg_wdata;
        REG_WEIGHT_4: weight_r[4] <= cfg_wdata;
        REG_WEIGHT_5: weight_r[5] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // window and scheduler
  glb_window #(
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sample    (in_tdata[SAMPLE_BITS-1:0]),
    .line_end  (in_tlast),
    .radius    (radius_r),
    .sel_ready (cell_ready[0]),
    .sel_ctl   (cell_ctl[0]),
    .sel_ops   (cell_ops[0])
  );

  assign cell_acc[0] = '0;

  // chain of tap cells, centre tap first
  for (genvar t = 0; t < MAX_RADIUS; t++) begin : g_tap
    if (t < MAX_RADIUS - 1) begin : g_mid
      glb_mac_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_RADIUS  (MAX_RADIUS),
        .TAP         (t)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (cell_ctl[t]),
        .acc_in    (cell_acc[t]),
        .ops_in    (cell_ops[t]),
        .weight    (weight_r[t]),
        .ready_in  (cell_ready[t+1]),
        .ready_out (cell_ready[t]),
        .ctl_out   (cell_ctl[t+1]),
        .acc_out   (cell_acc[t+1]),
        .ops_out   (cell_ops[t+1])
      );
    end else begin : g_end
      glb_mac_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_RADIUS  (MAX_RADIUS),
        .TAP         (t)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (cell_ctl[t]),
        .acc_in    (cell_acc[t]),
        .ops_in    (cell_ops[t]),
        .weight    (weight_r[t]),
        .ready_in  (cell_ready[t+1]),
        .ready_out (cell_ready[t]),
        .ctl_out   (cell_ctl[t+1]),
        .acc_out   (cell_acc[t+1]),
        .ops_out   ()
      );
    end
  end

  // drop the fraction (floor) and saturate to the sample range
  assign shifted = cell_acc[MAX_RADIUS][ACC_W-1:FRAC_BITS];

  always_comb begin
    priority if (shifted > SAT_HI) begin
      blurred = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shifted < SAT_LO) begin
      blurred = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      blurred = shifted[SAMPLE_BITS-1:0];
    end
  end

  // output register
  assign cell_ready[MAX_RADIUS] = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cell_ready[MAX_RADIUS]) begin
      out_valid_r <= cell_ctl[MAX_RADIUS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_ready[MAX_RADIUS] && cell_ctl[MAX_RADIUS].valid) begin
      out_blurred_r <= blurred;
      out_last_r    <= cell_ctl[MAX_RADIUS].last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_blurred_r);
  assign out_tlast  = out_last_r;

endmodule
